@@ rtl/core/dtml_pkg.sv @@
// Shared types and constants for the double-tap modifier lock.
`timescale 1ns / 1ps
`default_nettype none

package dtml_pkg;

	localparam int KEY_COUNT = 4;
	localparam int TIME_W    = 16;
	localparam int GAP_W     = 15;
	localparam int TAP_FLAG  = 15;

	localparam logic [1:0] OP_KEY     = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_SUSPEND = 2'd2;

	localparam logic [1:0] CFG_TAP_WINDOW = 2'd0;
	localparam logic [1:0] CFG_DT_WINDOW  = 2'd1;

	localparam logic [1:0] PAIR_FULL = 2'b11;

	localparam logic [TIME_W-1:0] TAP_WINDOW_RST = 16'd100;
	localparam logic [GAP_W-1:0]  DT_WINDOW_RST  = 15'd300;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [1:0]        key_index;
		logic              key_pressed;
		logic [TIME_W-1:0] event_time;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] tap_window;
		logic [GAP_W-1:0]  dt_window;
	} cfg_t;

	typedef struct packed {
		logic [KEY_COUNT-1:0][TIME_W-1:0] last_time;
		logic [KEY_COUNT-1:0][TIME_W-1:0] tap_rec;
		logic [1:0]                       shift_held;
		logic [1:0]                       shift_locked;
		logic [1:0]                       fn_held;
		logic [1:0]                       fn_locked;
	} state_t;

	typedef struct packed {
		logic shift_drive;
		logic symbol_layer;
		logic fn_layer;
		logic fn_extra_layer;
	} levels_t;

endpackage

`default_nettype wire

@@ rtl/core/double_tap_modifier_lock.sv @@
// Top level of the double-tap modifier lock: input stage, update, result register.
//
// Takes one word per cycle, with no stall of its own while results drain: a word
// waits in the input register, then the single update stage applies it to the key
// state and loads the result register, where the result waits until it is taken.
// The key state is written at the same edge as the result, so each word sees the
// effect of the one before it. The result register parts the two sides; the
// input keeps flowing while a result waits as long as the input stage is free.
// Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module double_tap_modifier_lock
	import dtml_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  key_index,
	input  wire logic        key_pressed,
	input  wire logic [15:0] event_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             shift_drive,
	output logic             symbol_layer,
	output logic             fn_layer,
	output logic             fn_extra_layer,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	levels_t levels_nxt;
	levels_t levels_q;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;

	dtml_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// result register free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode      <= opcode;
			item_s1.key_index   <= key_index;
			item_s1.key_pressed <= key_pressed;
			item_s1.event_time  <= event_time;
		end
	end

	dtml_update u_update (
		.item   (item_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt),
		.levels (levels_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			levels_q <= levels_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign shift_drive    = levels_q.shift_drive;
	assign symbol_layer   = levels_q.symbol_layer;
	assign fn_layer       = levels_q.fn_layer;
	assign fn_extra_layer = levels_q.fn_extra_layer;

	// a word in the input stage that moves on always lands in the result register
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("input stage word lost on advance");

	// key state only changes when a word is applied
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("key state changed without a word");

	// suspend leaves no valid tap record
	a_suspend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && item_s1.opcode == OP_SUSPEND |=>
		!(state_q.tap_rec[0][TAP_FLAG] || state_q.tap_rec[1][TAP_FLAG] ||
		  state_q.tap_rec[2][TAP_FLAG] || state_q.tap_rec[3][TAP_FLAG]))
		else $error("tap record survived suspend");

	// configuration holds without a write
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(cfg))
		else $error("configuration changed without a write");

endmodule

`default_nettype wire

@@ rtl/core/dtml_cfg_regs.sv @@
// Configuration registers: tap window and double-tap window.
`timescale 1ns / 1ps
`default_nettype none

module dtml_cfg_regs
	import dtml_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_window <= TAP_WINDOW_RST;
			cfg_q.dt_window  <= DT_WINDOW_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TAP_WINDOW: cfg_q.tap_window <= wr_data;
				CFG_DT_WINDOW:  cfg_q.dt_window  <= wr_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/dtml_update.sv @@
// Next-state and drive-level logic for one input word.
`timescale 1ns / 1ps
`default_nettype none

module dtml_update
	import dtml_pkg::*;
(
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	output state_t      nxt,
	output levels_t     levels
);

	logic [TIME_W-1:0] since;
	logic [TIME_W-1:0] prev;
	logic [TIME_W-1:0] tap_diff;
	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] tick_diff [KEY_COUNT];
	logic              quick;
	logic              dbl;
	logic [1:0]        key_bit;
	logic [1:0]        held_p;
	logic [1:0]        locked_p;
	logic [1:0]        held_n;
	logic [1:0]        locked_n;

	always_comb begin
		since    = item.event_time - cur.last_time[item.key_index];
		prev     = cur.tap_rec[item.key_index];
		tap_diff = item.event_time - prev;
		quick    = (since <= cfg.tap_window);
		dbl      = quick && prev[TAP_FLAG] && (tap_diff[GAP_W-1:0] <= cfg.dt_window);
		key_bit  = item.key_index[0] ? 2'b10 : 2'b01;
		held_p   = item.key_index[1] ? cur.fn_held : cur.shift_held;
		locked_p = item.key_index[1] ? cur.fn_locked : cur.shift_locked;
		now      = {item.event_time[TIME_W-1:1], 1'b1};

		held_n   = held_p;
		locked_n = locked_p;
		if (item.key_pressed) begin
			held_n = held_p | key_bit;
		end else if (dbl) begin
			locked_n = locked_p | key_bit;
		end else if (locked_p == PAIR_FULL) begin
			// releasing a key of a fully locked pair drops the whole pair
			held_n   = 2'b00;
			locked_n = 2'b00;
		end else begin
			held_n   = held_p & ~key_bit;
			locked_n = locked_p & ~key_bit;
		end

		for (int i = 0; i < KEY_COUNT; i++) begin
			tick_diff[i] = now - cur.tap_rec[i];
		end

		nxt = cur;
		case (item.opcode)
			OP_KEY: begin
				nxt.last_time[item.key_index] = item.event_time;
				if (!item.key_pressed) begin
					nxt.tap_rec[item.key_index] = quick ?
						{1'b1, item.event_time[GAP_W-1:0]} : '0;
				end
				if (item.key_index[1]) begin
					nxt.fn_held   = held_n;
					nxt.fn_locked = locked_n;
				end else begin
					nxt.shift_held   = held_n;
					nxt.shift_locked = locked_n;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < KEY_COUNT; i++) begin
					if (cur.tap_rec[i][TAP_FLAG] &&
					    (tick_diff[i][GAP_W-1:0] > cfg.dt_window)) begin
						nxt.tap_rec[i] = '0;
					end
				end
			end
			OP_SUSPEND: begin
				nxt.tap_rec = '0;
			end
			default: ;
		endcase

		levels.shift_drive    = (nxt.shift_held != 2'b00);
		levels.symbol_layer   = (nxt.shift_held == PAIR_FULL);
		levels.fn_layer       = (nxt.fn_held != 2'b00);
		levels.fn_extra_layer = (nxt.fn_held == PAIR_FULL);
	end

endmodule

`default_nettype wire

@@ tb/sv/lock_levels_check.sv @@
// Checker for the double-tap modifier lock: tracks key state, predicts levels, compares.
`timescale 1ns / 1ps

module lock_levels_check
	import dtml_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [1:0]  key_index,
	input  logic        key_pressed,
	input  logic [15:0] event_time,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        shift_drive,
	input  logic        symbol_layer,
	input  logic        fn_layer,
	input  logic        fn_extra_layer,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          words_due
);

	logic [TIME_W-1:0] tap_win;
	logic [GAP_W-1:0]  dt_win;
	logic [TIME_W-1:0] last_time [KEY_COUNT];
	logic [TIME_W-1:0] tap_rec [KEY_COUNT];
	logic [1:0]        held [2];    // [0] shift pair, [1] fn pair
	logic [1:0]        locked [2];
	levels_t           levels_due [$];
	levels_t           got;
	levels_t           want;
	int                errs = 0;

	task automatic report(input string what);
		if (errs < 50)
			$display("%0t ns: mismatch: %s", $time, what);
		errs++;
	endtask

	task automatic check_level(input string name, input logic g, input logic w);
		if (g !== w)
			report($sformatf("%s got %b want %b", name, g, w));
	endtask

	// Applies one word to the tracked key state and returns the levels after it.
	function automatic levels_t next_levels(input item_t w);
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] prev;
		logic [TIME_W-1:0] now;
		logic [GAP_W-1:0]  gap;
		logic [1:0]        b;
		logic              pr;
		logic              dbl;
		levels_t           lv;

		pr = w.key_index[1];
		b = 2'b01 << w.key_index[0];
		case (w.opcode)
			OP_KEY: begin
				if (w.key_pressed) begin
					held[pr] |= b;
				end else begin
					since = w.event_time - last_time[w.key_index];
					dbl = 1'b0;
					if (since > tap_win) begin
						tap_rec[w.key_index] = '0;
					end else begin
						prev = tap_rec[w.key_index];
						tap_rec[w.key_index] = w.event_time;
						tap_rec[w.key_index][TAP_FLAG] = 1'b1;
						gap = w.event_time[GAP_W-1:0] - prev[GAP_W-1:0];
						dbl = prev[TAP_FLAG] && (gap <= dt_win);
					end
					if (dbl) begin
						locked[pr] |= b;
					end else if (locked[pr] == PAIR_FULL) begin
						held[pr] = '0;
						locked[pr] = '0;
					end else begin
						held[pr] &= ~b;
						locked[pr] &= ~b;
					end
				end
				last_time[w.key_index] = w.event_time;
			end
			OP_TICK: begin
				now = w.event_time;
				now[0] = 1'b1;
				for (int i = 0; i < KEY_COUNT; i++) begin
					if (tap_rec[i][TAP_FLAG]) begin
						gap = now[GAP_W-1:0] - tap_rec[i][GAP_W-1:0];
						if (gap > dt_win)
							tap_rec[i] = '0;
					end
				end
			end
			OP_SUSPEND: begin
				for (int i = 0; i < KEY_COUNT; i++)
					tap_rec[i] = '0;
			end
			default: ;
		endcase
		lv.shift_drive    = |held[0];
		lv.symbol_layer   = (held[0] == PAIR_FULL);
		lv.fn_layer       = |held[1];
		lv.fn_extra_layer = (held[1] == PAIR_FULL);
		return lv;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_win = TAP_WINDOW_RST;
			dt_win = DT_WINDOW_RST;
			for (int i = 0; i < KEY_COUNT; i++) begin
				last_time[i] = '0;
				tap_rec[i] = '0;
			end
			for (int p = 0; p < 2; p++) begin
				held[p] = '0;
				locked[p] = '0;
			end
			levels_due.delete();
			words_due <= 0;
			mismatches <= errs;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TAP_WINDOW: tap_win = cfg_data;
					CFG_DT_WINDOW:  dt_win = cfg_data[GAP_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = levels_t'({shift_drive, symbol_layer, fn_layer, fn_extra_layer});
				if (levels_due.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					want = levels_due.pop_front();
					check_level("shift_drive", got.shift_drive, want.shift_drive);
					check_level("symbol_layer", got.symbol_layer, want.symbol_layer);
					check_level("fn_layer", got.fn_layer, want.fn_layer);
					check_level("fn_extra_layer", got.fn_extra_layer, want.fn_extra_layer);
				end
			end
			if (in_valid && in_ready)
				levels_due.push_back(next_levels(item_t'({opcode, key_index, key_pressed,
					event_time})));
			words_due <= levels_due.size();
			mismatches <= errs;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the double-tap modifier lock: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import dtml_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;
	localparam int         LONG_HOLD   = 300;
	localparam int         PHASE_WORDS = 240;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [1:0]  key_index;
	logic        key_pressed;
	logic [15:0] event_time;
	logic        out_valid;
	logic        out_ready;
	logic        shift_drive;
	logic        symbol_layer;
	logic        fn_layer;
	logic        fn_extra_layer;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          mismatches;
	int          words_due;

	int          sent = 0;
	int          rx_gap_pct = 0;
	int          tx_gap_pct = 0;
	bit          hold_req = 1'b0;
	logic [15:0] ms;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	double_tap_modifier_lock i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key_index(key_index), .key_pressed(key_pressed),
		.event_time(event_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.shift_drive(shift_drive), .symbol_layer(symbol_layer),
		.fn_layer(fn_layer), .fn_extra_layer(fn_extra_layer),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lock_levels_check i_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key_index(key_index), .key_pressed(key_pressed),
		.event_time(event_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.shift_drive(shift_drive), .symbol_layer(symbol_layer),
		.fn_layer(fn_layer), .fn_extra_layer(fn_extra_layer),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .words_due(words_due)
	);

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(20, 4);
		return $urandom_range(120, 30);
	endfunction

	// a duration that straddles window w
	function automatic int near(input int w);
		return $urandom_range(w + w / 4 + 2, 0);
	endfunction

	task automatic send(input logic [1:0] op, input logic [1:0] k, input logic p,
		input logic [15:0] t);
		int g;
		if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			g = gap_len();
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key_index <= k;
		key_pressed <= p;
		event_time <= t;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// hold the input until every expected word has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
	endtask

	task automatic set_windows(input int tw, input int dw, input bit spare);
		logic [1:0]  idx [4];
		logic [15:0] val [4];
		int          n;
		n = 0;
		if (spare) begin
			idx[0] = CFG_SPARE_A;
			val[0] = 16'($urandom_range(65535));
			idx[1] = CFG_SPARE_B;
			val[1] = 16'($urandom_range(65535));
			n = 2;
		end
		idx[n] = CFG_TAP_WINDOW;
		val[n] = 16'(tw);
		idx[n + 1] = CFG_DT_WINDOW;
		val[n + 1] = 16'(dw);
		val[n + 1][15] = 1'($urandom_range(1));   // upper bit must be dropped
		n += 2;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_random(input int count, input int tw, input int dw);
		int         first;
		int         r;
		logic [1:0] k;
		first = sent;
		while (sent - first < count) begin
			r = $urandom_range(99);
			k = 2'($urandom_range(3));
			if (r < 55) begin
				// tap, optional other key, tap again on the same key
				ms += 16'($urandom_range(40));
				send(OP_KEY, k, 1'b1, ms);
				ms += 16'(near(tw));
				send(OP_KEY, k, 1'b0, ms);
				if ($urandom_range(3) == 0) begin
					ms += 16'($urandom_range(20));
					send(OP_KEY, 2'($urandom_range(3)), 1'($urandom_range(1)), ms);
				end
				ms += 16'($urandom_range(near(dw)));
				send(OP_KEY, k, 1'b1, ms);
				ms += 16'(near(tw));
				send(OP_KEY, k, 1'b0, ms);
			end else if (r < 70) begin
				ms += 16'($urandom_range(150));
				send(OP_KEY, k, 1'($urandom_range(1)), ms);
			end else if (r < 80) begin
				ms += 16'(near(dw));
				send(OP_TICK, k, 1'($urandom_range(1)), ms);
			end else if (r < 85) begin
				send(OP_SUSPEND, k, 1'($urandom_range(1)), 16'($urandom_range(65535)));
			end else if (r < 90) begin
				send(OP_UNUSED, k, 1'($urandom_range(1)), 16'($urandom_range(65535)));
			end else begin
				send(2'($urandom_range(3)), k, 1'($urandom_range(1)),
					16'($urandom_range(65535)));
			end
			if ($urandom_range(199) == 0)
				settle();
		end
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				out_ready <= 1'b0;
			end else if (rx_gap_pct != 0 && $urandom_range(99) < rx_gap_pct) begin
				idle_left = gap_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("FAIL double_tap_modifier_lock");
		$finish;
	end

	initial begin
		int tw;
		int dw;
		bit spare;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_KEY;
		key_index = 2'd0;
		key_pressed = 1'b0;
		event_time = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TAP_WINDOW;
		cfg_data = '0;
		ms = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		rx_gap_pct = 20;
		tx_gap_pct = 20;

		// directed part, reset windows (tap 100, double tap 300)
		send(OP_UNUSED, 2'd3, 1'b1, 16'hffff);
		send(OP_KEY, 2'd0, 1'b1, 16'd0);
		send(OP_KEY, 2'd0, 1'b0, 16'd100);      // tap right at the window edge
		send(OP_KEY, 2'd0, 1'b1, 16'd150);
		send(OP_KEY, 2'd0, 1'b0, 16'd200);      // double tap locks left shift
		send(OP_KEY, 2'd1, 1'b1, 16'd210);
		send(OP_KEY, 2'd1, 1'b0, 16'd260);
		send(OP_KEY, 2'd1, 1'b1, 16'd300);
		send(OP_KEY, 2'd1, 1'b0, 16'd350);      // both shifts locked
		send(OP_KEY, 2'd0, 1'b1, 16'd400);
		send(OP_KEY, 2'd0, 1'b0, 16'd700);      // slow release clears the pair
		send(OP_TICK, 2'd3, 1'b1, 16'd1000);
		send(OP_KEY, 2'd2, 1'b1, 16'd65500);
		send(OP_KEY, 2'd2, 1'b0, 16'd30);       // tap across the timestamp wrap
		send(OP_KEY, 2'd2, 1'b1, 16'd60);
		send(OP_KEY, 2'd2, 1'b0, 16'd90);
		send(OP_KEY, 2'd3, 1'b1, 16'd100);
		send(OP_KEY, 2'd3, 1'b0, 16'd150);
		send(OP_TICK, 2'd0, 1'b0, 16'd388);     // gap 299: record kept
		send(OP_TICK, 2'd0, 1'b0, 16'd390);     // gap 301: left fn record dropped
		send(OP_KEY, 2'd3, 1'b1, 16'd400);
		send(OP_KEY, 2'd3, 1'b0, 16'd420);      // fn pair now locked
		send(OP_SUSPEND, 2'd1, 1'b1, 16'hffff);
		send(OP_KEY, 2'd2, 1'b1, 16'd450);
		send(OP_KEY, 2'd2, 1'b0, 16'd470);      // no record after suspend: pair cleared
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			spare = 1'b0;
			case (ph)
				0: begin tw = 100; dw = 300; rx_gap_pct = 20; tx_gap_pct = 20; end
				1: begin tw = 0; dw = 0; rx_gap_pct = 0; tx_gap_pct = 0; end
				2: begin
					tw = 65535; dw = 32767; spare = 1'b1;
					rx_gap_pct = 30; tx_gap_pct = 10;
				end
				3: begin tw = 20; dw = 60; rx_gap_pct = 10; tx_gap_pct = 40; end
				4: begin
					tw = $urandom_range(400); dw = $urandom_range(1000);
					rx_gap_pct = 40; tx_gap_pct = 5;
				end
				5: begin tw = 100; dw = 300; rx_gap_pct = 50; tx_gap_pct = 50; end
				6: begin
					tw = $urandom_range(65535); dw = $urandom_range(32767);
					rx_gap_pct = 15; tx_gap_pct = 15;
				end
				default: begin tw = 1; dw = 32767; rx_gap_pct = 25; tx_gap_pct = 0; end
			endcase
			if (ph != 0)
				set_windows(tw, dw, spare);
			if (ph == 2) begin
				// receiver holds off while words keep coming: input must stall
				hold_req = 1'b1;
				tx_gap_pct = 0;
				feed_random(40, tw, dw);
				tx_gap_pct = 10;
				feed_random(PHASE_WORDS - 40, tw, dw);
			end else begin
				feed_random(PHASE_WORDS, tw, dw);
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS double_tap_modifier_lock");
		else
			$display("FAIL double_tap_modifier_lock");
		$finish;
	end

endmodule
